[hw/rtl/svr_pkg.sv]
package svr_pkg;

    // sizing
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int PHASE_BITS       = 32;
    localparam int SAMPLE_BITS      = 16;

    localparam int SINE_LG   = $clog2(SINE_TABLE_DEPTH);
    localparam int QUAD_BITS = SINE_LG - 2;
    localparam int QUAD_SIZE = 1 << QUAD_BITS;
    localparam int MAG_W     = 15;

    localparam int A4_W     = 31;
    localparam int A4_RESET = 39370534;
    localparam int AMP_W    = 16;
    localparam int GAIN_W   = 17;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int OCT_W    = 4;
    localparam int SEMI_W   = 4;
    localparam int RATIO_W  = 17;

    // shared multiplier
    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // pitch
    localparam int OCTAVE           = 12;
    localparam int NOTE_OFFSET      = 3;
    localparam int PITCH_SHIFT_BASE = 22;
    localparam int PITCH_PROD_W     = A4_W + RATIO_W;
    localparam int SHIFT_W          = 5;

    // amplitude: round(vel * 0.15 * 65536 / 127)
    localparam int AMP_NUM  = 98304;
    localparam int AMP_BIAS = 635;
    localparam int AMP_DEN  = 1270;

    // release decay: g = (g * 99 + 50) / 100, divide by reciprocal
    localparam int GAIN_ONE   = 65536;
    localparam int GAIN_STOP  = 327;
    localparam int DECAY_NUM  = 99;
    localparam int DECAY_BIAS = 50;
    localparam int DIV_SHIFT  = 30;
    localparam int DIV_MUL    = 10737419;

    // output rounding
    localparam int SAMPLE_PROD_W = 48;
    localparam int SAMPLE_SHIFT  = SAMPLE_PROD_W - SAMPLE_BITS;

    // quarter-wave polynomial in q30
    localparam logic [63:0] K1 = 64'd1686629713;
    localparam logic [63:0] K3 = 64'd693598668;
    localparam logic [63:0] K5 = 64'd85569306;
    localparam logic [63:0] K7 = 64'd5026995;
    localparam logic [63:0] K9 = 64'd172272;

    typedef enum logic [1:0] {
        FUNC_NOTE_ON       = 2'd0,
        FUNC_RELEASE_OFF   = 2'd1,
        FUNC_IMMEDIATE_OFF = 2'd2,
        FUNC_TICK          = 2'd3
    } func_t;

    typedef struct packed {
        func_t              func;
        logic [NOTE_W-1:0]  note;
        logic [VEL_W-1:0]   velocity;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          voice_active;
    } out_item_t;

    typedef logic [MAG_W-1:0]   mag_t;
    typedef mag_t               sine_rom_t [QUAD_SIZE];
    typedef logic [AMP_W-1:0]   amp_rom_t  [1 << VEL_W];
    typedef logic [OCT_W-1:0]   oct_rom_t  [1 << NOTE_W];
    typedef logic [SEMI_W-1:0]  semi_rom_t [1 << NOTE_W];

    localparam logic [RATIO_W-1:0] RATIO_ROM [OCTAVE] = '{
        17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
        17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
    };

    // magnitude of sin(pi/2 * xn / QUAD_SIZE) in q0.15, clipped
    function automatic mag_t sine_mag_calc(input int xn);
        logic [63:0] u;
        logic [63:0] s;
        logic [63:0] p;
        logic [63:0] y;
        logic [63:0] m;
        u = 64'(xn) << (30 - QUAD_BITS);
        s = (u * u) >> 30;
        p = K9;
        p = K7 - ((s * p) >> 30);
        p = K5 - ((s * p) >> 30);
        p = K3 - ((s * p) >> 30);
        p = K1 - ((s * p) >> 30);
        y = (u * p) >> 30;
        m = (y + 64'd16384) >> 15;
        if (m > 64'd32767) begin
            m = 64'd32767;
        end
        return m[MAG_W-1:0];
    endfunction

    function automatic sine_rom_t sine_rom_init();
        sine_rom_t r;
        for (int i = 0; i < QUAD_SIZE; i++) begin
            r[i] = sine_mag_calc(i);
        end
        return r;
    endfunction

    function automatic amp_rom_t amp_rom_init();
        amp_rom_t r;
        for (int v = 0; v < (1 << VEL_W); v++) begin
            r[v] = AMP_W'((v * AMP_NUM + AMP_BIAS) / AMP_DEN);
        end
        return r;
    endfunction

    function automatic oct_rom_t oct_rom_init();
        oct_rom_t r;
        for (int n = 0; n < (1 << NOTE_W); n++) begin
            r[n] = OCT_W'((n + NOTE_OFFSET) / OCTAVE);
        end
        return r;
    endfunction

    function automatic semi_rom_t semi_rom_init();
        semi_rom_t r;
        for (int n = 0; n < (1 << NOTE_W); n++) begin
            r[n] = SEMI_W'((n + NOTE_OFFSET) % OCTAVE);
        end
        return r;
    endfunction

    localparam sine_rom_t SINE_ROM  = sine_rom_init();
    localparam mag_t      SINE_PEAK = sine_mag_calc(QUAD_SIZE);
    localparam amp_rom_t  AMP_ROM   = amp_rom_init();
    localparam oct_rom_t  OCT_ROM   = oct_rom_init();
    localparam semi_rom_t SEMI_ROM  = semi_rom_init();

endpackage

[hw/rtl/sine_voice_with_release.sv]
// sine voice with exponential release, one event per request, one shared multiplier
// note on: pitch multiply, pitch set, no result; release and immediate off act in idle
// tick: sine, gain and sample passes through the single 31x24 multiplier, then decay
// multiply and decay set while a release runs, then finish; an idle voice goes to finish
// one event at a time; finish holds while the previous result still waits for m_ready
// reset: aresetn synchronous active low; voice idle, gain and amplitude zero, a4 step 39370534
module sine_voice_with_release (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // event requests
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  svr_pkg::in_item_t                    s_item,
    // sample results
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output svr_pkg::out_item_t                   m_item,
    // a4 phase step register
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [svr_pkg::A4_W-1:0]             cfg_data
);

    // sequencer, one-hot
    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_PITCH_MUL = 9'b000000010,  // a4 * ratio
        ST_PITCH_SET = 9'b000000100,  // round and shift into phase step
        ST_SINE_MUL  = 9'b000001000,  // |sine| * amplitude
        ST_GAIN_MUL  = 9'b000010000,  // * release gain
        ST_SAMPLE    = 9'b000100000,  // round sample, advance phase, gain * 99
        ST_DECAY_MUL = 9'b001000000,  // (gain * 99 + 50) * reciprocal of 100
        ST_DECAY_SET = 9'b010000000,  // new gain, stop check
        ST_FINISH    = 9'b100000000   // park result in output register
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [svr_pkg::A4_W-1:0]        a4_reg;
    logic [svr_pkg::PHASE_BITS-1:0]  phase_reg;
    logic [svr_pkg::PHASE_BITS-1:0]  step_reg;
    logic [svr_pkg::AMP_W-1:0]       amp_reg;
    logic [svr_pkg::GAIN_W-1:0]      gain_reg;
    logic [svr_pkg::NOTE_W-1:0]      note_reg;
    logic                            neg_reg;
    logic [svr_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic [svr_pkg::PROD_W-1:0]      prod_reg;
    logic [svr_pkg::PROD_W-1:0]      prod_next;
    logic                            m_valid_reg;
    svr_pkg::out_item_t              out_item_reg;

    logic                            s_fire;
    logic                            out_load;

    // shared multiplier operands
    logic [svr_pkg::MUL_A_W-1:0]     mul_a;
    logic [svr_pkg::MUL_B_W-1:0]     mul_b;

    // sine lookup from the top phase bits, quarter-wave folded
    logic [svr_pkg::SINE_LG-1:0]     sine_idx;
    logic [1:0]                      quad;
    logic [svr_pkg::QUAD_BITS-1:0]   quad_pos;
    logic [svr_pkg::QUAD_BITS-1:0]   fold_pos;
    logic                            at_peak;
    svr_pkg::mag_t                   sine_mag;

    // pitch rounding shift
    logic [svr_pkg::SHIFT_W-1:0]        pitch_sh;
    logic [svr_pkg::PITCH_PROD_W:0]     pitch_rnd;
    logic [svr_pkg::PITCH_PROD_W:0]     pitch_full;

    // sample rounding
    logic [svr_pkg::SAMPLE_PROD_W:0]    smp_rnd;
    logic [svr_pkg::SAMPLE_BITS-1:0]    smp_mag;

    // decay
    logic [svr_pkg::GAIN_W-1:0]      gain_eff;
    logic [svr_pkg::MUL_B_W-1:0]     decay_x;
    logic [svr_pkg::GAIN_W-1:0]      gain_new;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = out_item_reg;

    // result register frees up as soon as the current one is taken
    assign out_load  = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    assign sine_idx = phase_reg[svr_pkg::PHASE_BITS-1 -: svr_pkg::SINE_LG];
    assign quad     = sine_idx[svr_pkg::SINE_LG-1 -: 2];
    assign quad_pos = sine_idx[svr_pkg::QUAD_BITS-1:0];
    // falling quarters mirror; position zero there is the crest itself
    assign fold_pos = quad[0] ? (svr_pkg::QUAD_BITS)'(0) - quad_pos : quad_pos;
    assign at_peak  = quad[0] && (quad_pos == '0);
    assign sine_mag = at_peak ? svr_pkg::SINE_PEAK : svr_pkg::SINE_ROM[fold_pos];

    assign gain_eff = (gain_reg != '0) ? gain_reg : svr_pkg::GAIN_W'(svr_pkg::GAIN_ONE);
    assign decay_x  = prod_reg[svr_pkg::MUL_B_W-1:0] + svr_pkg::MUL_B_W'(svr_pkg::DECAY_BIAS);
    assign gain_new = prod_reg[svr_pkg::DIV_SHIFT +: svr_pkg::GAIN_W];

    // step = (a4 * ratio + half) >> (22 - octave)
    assign pitch_sh   = svr_pkg::SHIFT_W'(svr_pkg::PITCH_SHIFT_BASE)
                      - svr_pkg::SHIFT_W'(svr_pkg::OCT_ROM[note_reg]);
    assign pitch_rnd  = {1'b0, prod_reg[svr_pkg::PITCH_PROD_W-1:0]}
                      + ((svr_pkg::PITCH_PROD_W+1)'(1) << (pitch_sh - 1'b1));
    assign pitch_full = pitch_rnd >> pitch_sh;

    // sample magnitude = (m + half) >> k, never overflows the sample width
    assign smp_rnd = {1'b0, prod_reg[svr_pkg::SAMPLE_PROD_W-1:0]}
                   + ((svr_pkg::SAMPLE_PROD_W+1)'(1) << (svr_pkg::SAMPLE_SHIFT - 1));
    assign smp_mag = smp_rnd[svr_pkg::SAMPLE_SHIFT +: svr_pkg::SAMPLE_BITS];

    // operand select for the one multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PITCH_MUL: begin
                mul_a = a4_reg;
                mul_b = svr_pkg::MUL_B_W'(svr_pkg::RATIO_ROM[svr_pkg::SEMI_ROM[note_reg]]);
            end
            ST_SINE_MUL: begin
                mul_a = svr_pkg::MUL_A_W'(sine_mag);
                mul_b = svr_pkg::MUL_B_W'(amp_reg);
            end
            ST_GAIN_MUL: begin
                mul_a = prod_reg[svr_pkg::MUL_A_W-1:0];
                mul_b = svr_pkg::MUL_B_W'(gain_eff);
            end
            ST_SAMPLE: begin
                mul_a = svr_pkg::MUL_A_W'(gain_reg);
                mul_b = svr_pkg::MUL_B_W'(svr_pkg::DECAY_NUM);
            end
            ST_DECAY_MUL: begin
                mul_a = svr_pkg::MUL_A_W'(svr_pkg::DIV_MUL);
                mul_b = decay_x;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = {{(svr_pkg::PROD_W-svr_pkg::MUL_A_W){1'b0}}, mul_a}
                     * {{(svr_pkg::PROD_W-svr_pkg::MUL_B_W){1'b0}}, mul_b};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_item.func)
                        svr_pkg::FUNC_NOTE_ON: state_next = ST_PITCH_MUL;
                        svr_pkg::FUNC_TICK: begin
                            // idle voice skips straight to a zero result
                            state_next = (step_reg == '0) ? ST_FINISH : ST_SINE_MUL;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PITCH_MUL: state_next = ST_PITCH_SET;
            ST_PITCH_SET: state_next = ST_IDLE;
            ST_SINE_MUL:  state_next = ST_GAIN_MUL;
            ST_GAIN_MUL:  state_next = ST_SAMPLE;
            ST_SAMPLE:    state_next = (gain_reg != '0) ? ST_DECAY_MUL : ST_FINISH;
            ST_DECAY_MUL: state_next = ST_DECAY_SET;
            ST_DECAY_SET: state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and voice state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            a4_reg      <= svr_pkg::A4_W'(svr_pkg::A4_RESET);
            phase_reg   <= '0;
            step_reg    <= '0;
            amp_reg     <= '0;
            gain_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                a4_reg <= cfg_data;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        case (s_item.func)
                            svr_pkg::FUNC_NOTE_ON: begin
                                phase_reg <= '0;
                                gain_reg  <= '0;
                                amp_reg   <= svr_pkg::AMP_ROM[s_item.velocity];
                            end
                            svr_pkg::FUNC_RELEASE_OFF: begin
                                // a running decay is left alone
                                if (gain_reg == '0) begin
                                    gain_reg <= svr_pkg::GAIN_W'(svr_pkg::GAIN_ONE);
                                end
                            end
                            svr_pkg::FUNC_IMMEDIATE_OFF: begin
                                step_reg <= '0;
                                gain_reg <= '0;
                            end
                            default: begin
                                gain_reg <= gain_reg;
                            end
                        endcase
                    end
                end
                ST_PITCH_SET: begin
                    step_reg <= pitch_full[svr_pkg::PHASE_BITS-1:0];
                end
                ST_SAMPLE: begin
                    phase_reg <= phase_reg + step_reg;
                end
                ST_DECAY_SET: begin
                    // decay at or below the floor ends the note
                    if (gain_new <= svr_pkg::GAIN_W'(svr_pkg::GAIN_STOP)) begin
                        step_reg <= '0;
                        gain_reg <= '0;
                    end else begin
                        gain_reg <= gain_new;
                    end
                end
                default: begin
                    gain_reg <= gain_reg;
                end
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;

        if (s_fire) begin
            note_reg <= s_item.note;
        end

        if (state_reg == ST_SINE_MUL) begin
            neg_reg <= quad[1];
        end

        if (s_fire && (s_item.func == svr_pkg::FUNC_TICK)) begin
            sample_reg <= '0;
        end else if (state_reg == ST_SAMPLE) begin
            sample_reg <= neg_reg ? ('0 - smp_mag) : smp_mag;
        end

        if (out_load) begin
            out_item_reg.sample       <= sample_reg;
            out_item_reg.voice_active <= (step_reg != '0);
        end
    end

endmodule

[hw/rtl/svr_checker.sv]
module svr_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input svr_pkg::in_item_t            s_item,
    input logic                         m_valid,
    input logic                         m_ready,
    input svr_pkg::out_item_t           m_item,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [svr_pkg::A4_W-1:0]     cfg_data
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result dropped or changed while stalled");

    // no result right out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a tick leaves the sequencer busy in the cycle after it is accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.func == svr_pkg::FUNC_TICK |=> !s_ready)
        else $error("tick request did not occupy the sequencer");

    // control events never create a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.func != svr_pkg::FUNC_TICK && !m_valid |=> !m_valid)
        else $error("result produced by a non-tick request");

endmodule

bind sine_voice_with_release svr_checker u_svr_checker (.*);
